/* hw/rtl/kmrd_pkg.sv */
package kmrd_pkg;

    // Fixed field widths of the sample, result and configuration words.
    localparam int ROW_W      = 3;
    localparam int RAW_W      = 12;
    localparam int TIME_W     = 32;
    localparam int DELAY_W    = 8;
    localparam int KEYS_CFG_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_DELAY_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEYS_IN_USE      = 2'd1;

    // Configuration reset values.
    localparam logic [DELAY_W-1:0]    RELEASE_DELAY_RESET = 8'd10;
    localparam logic [KEYS_CFG_W-1:0] KEYS_IN_USE_RESET   = 4'd12;

    // Debounce state of one key.
    typedef struct packed {
        logic              active;
        logic              last_high;
        logic [TIME_W-1:0] start_ms;
    } key_state_t;

endpackage

/* hw/rtl/kmrd_sample_if.sv */
interface kmrd_sample_if;
    logic                          valid;
    logic                          ready;
    logic [kmrd_pkg::ROW_W-1:0]    row_index;
    logic [kmrd_pkg::RAW_W-1:0]    raw_keys;
    logic [kmrd_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output row_index, output raw_keys, output now_ms,
                    input ready);
    modport sink   (input valid, input row_index, input raw_keys, input now_ms,
                    output ready);
endinterface

/* hw/rtl/kmrd_result_if.sv */
interface kmrd_result_if;
    logic                          valid;
    logic                          ready;
    logic [kmrd_pkg::ROW_W-1:0]    row_out;
    logic [kmrd_pkg::RAW_W-1:0]    debounced_keys;

    modport source (output valid, output row_out, output debounced_keys, input ready);
    modport sink   (input valid, input row_out, input debounced_keys, output ready);
endinterface

/* hw/rtl/kmrd_cfg_if.sv */
interface kmrd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [kmrd_pkg::CFG_IDX_W-1:0]    index;
    logic [kmrd_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/key_matrix_release_debounce.sv */
// Channel  Role    Word
// -------  ------  ------------------------------------------------
// sample   sink    row_index, raw_keys, now_ms
// result   source  row_out, debounced_keys
// cfg      sink    index, data (release_delay_ms, keys_in_use)
//
// A new sample word is taken only once the lane stage is empty: the row's key
// state is read from the state memory at acceptance and written back by the
// lanes as the word leaves the lane stage, so no new word enters before then.
// An accepted word passes the lane stage register, then the output register.
// Reset clears the per-row valid bits at once; there is no clearing pass.
// A stalled result holds in the output register while one more sample waits
// in the lane stage; cfg is always ready.
module key_matrix_release_debounce #(
    parameter int ROWS         = 8,
    parameter int KEYS_PER_ROW = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    kmrd_sample_if.sink  sample,
    kmrd_result_if.source result,
    kmrd_cfg_if.sink     cfg
);

    localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [kmrd_pkg::DELAY_W-1:0]    release_delay_reg;
    logic [kmrd_pkg::KEYS_CFG_W-1:0] keys_in_use_reg;

    logic                            s1_valid_reg;
    logic [kmrd_pkg::ROW_W-1:0]      s1_row_reg;
    logic [kmrd_pkg::RAW_W-1:0]      s1_raw_reg;
    logic [kmrd_pkg::TIME_W-1:0]     s1_now_reg;

    logic                            out_valid_reg;
    logic [kmrd_pkg::ROW_W-1:0]      out_row_reg;
    logic [kmrd_pkg::RAW_W-1:0]      out_keys_reg;
    logic [kmrd_pkg::RAW_W-1:0]      keys_next;

    logic                            sample_fire;
    logic                            s1_fire;
    logic                            s1_in_range;
    logic [KEYS_PER_ROW-1:0]         in_use;
    logic [KEYS_PER_ROW-1:0]         level;

    kmrd_pkg::key_state_t [KEYS_PER_ROW-1:0] row_cur;
    kmrd_pkg::key_state_t [KEYS_PER_ROW-1:0] row_nxt;

    // Configuration writes; writes beyond the register list are dropped.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            release_delay_reg <= kmrd_pkg::RELEASE_DELAY_RESET;
            keys_in_use_reg   <= kmrd_pkg::KEYS_IN_USE_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == kmrd_pkg::REG_RELEASE_DELAY_MS)
            begin
                release_delay_reg <= cfg.data;
            end
            else if (cfg.index == kmrd_pkg::REG_KEYS_IN_USE)
            begin
                keys_in_use_reg <= cfg.data[kmrd_pkg::KEYS_CFG_W-1:0];
            end
        end
    end

    // Handshakes: the lane stage must be empty before a new word enters.
    assign sample.ready = !s1_valid_reg;
    assign sample_fire  = sample.valid && !s1_valid_reg;
    assign s1_fire      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign s1_in_range  = ({{(32-kmrd_pkg::ROW_W){1'b0}}, s1_row_reg} < 32'(ROWS));

    // Lane stage holding register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            s1_row_reg <= sample.row_index;
            s1_raw_reg <= sample.raw_keys;
            s1_now_reg <= sample.now_ms;
        end
    end

    // Per-row key state memory.
    kmrd_state_mem #(
        .ROWS         (ROWS),
        .KEYS_PER_ROW (KEYS_PER_ROW),
        .ROW_AW       (ROW_AW)
    ) u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (sample_fire),
        .rd_addr (ROW_AW'(sample.row_index)),
        .rd_data (row_cur),
        .wr_en   (s1_fire && s1_in_range),
        .wr_addr (ROW_AW'(s1_row_reg)),
        .wr_data (row_nxt)
    );

    // One debounce lane per key of the row.
    for (genvar j = 0; j < KEYS_PER_ROW; j++)
    begin : g_lane
        assign in_use[j] = (5'(j) < {1'b0, keys_in_use_reg});

        if (j < kmrd_pkg::RAW_W)
        begin : g_raw
            assign level[j] = s1_raw_reg[j];
        end
        else
        begin : g_noraw
            assign level[j] = 1'b0;
        end

        kmrd_lane u_lane (
            .cur      (row_cur[j]),
            .level    (level[j]),
            .en       (in_use[j]),
            .now_ms   (s1_now_reg),
            .delay_ms (release_delay_reg),
            .nxt      (row_nxt[j])
        );
    end

    // Merge: pack the reported keys of the lanes into the result word.
    for (genvar b = 0; b < kmrd_pkg::RAW_W; b++)
    begin : g_pack
        if (b < KEYS_PER_ROW)
        begin : g_key
            assign keys_next[b] = row_nxt[b].active && in_use[b] && s1_in_range;
        end
        else
        begin : g_none
            assign keys_next[b] = 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_row_reg  <= s1_row_reg;
            out_keys_reg <= keys_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.row_out        = out_row_reg;
    assign result.debounced_keys = out_keys_reg;

`ifndef NO_ASSERTIONS
    // An accepted word always occupies the lane stage in the next cycle.
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> s1_valid_reg)
        else $error("accepted word did not reach the lane stage");

    // No two words are accepted in consecutive cycles.
    a_no_back_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !(sample.valid && sample.ready))
        else $error("words accepted in consecutive cycles");

    // A row beyond the matrix reports no pressed key.
    a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && ({{(32-kmrd_pkg::ROW_W){1'b0}}, result.row_out} >= 32'(ROWS))
        |-> result.debounced_keys == '0)
        else $error("out of range row reported keys");

    // A waiting result never changes while the lane stage holds a word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready && s1_valid_reg |=> $stable(out_keys_reg))
        else $error("stalled result overwritten");
`endif

endmodule

/* hw/rtl/kmrd_lane.sv */
module kmrd_lane (
    input  kmrd_pkg::key_state_t          cur,
    input  logic                          level,
    input  logic                          en,
    input  logic [kmrd_pkg::TIME_W-1:0]   now_ms,
    input  logic [kmrd_pkg::DELAY_W-1:0]  delay_ms,
    output kmrd_pkg::key_state_t          nxt
);

    logic [kmrd_pkg::TIME_W-1:0] elapsed;

    // Elapsed time since the first low sample wraps with the timestamp.
    assign elapsed = now_ms - cur.start_ms;

    // Press shows at once; release waits for a later low sample past the delay.
    always_comb
    begin
        nxt = cur;
        if (en && (cur.active != level))
        begin
            priority if (level)
            begin
                nxt.active    = 1'b1;
                nxt.last_high = 1'b1;
            end
            else if (cur.last_high)
            begin
                nxt.last_high = 1'b0;
                nxt.start_ms  = now_ms;
            end
            else
            begin
                // A key still inside its hold-off stays pressed.
                if (elapsed >= {{(kmrd_pkg::TIME_W-kmrd_pkg::DELAY_W){1'b0}}, delay_ms})
                begin
                    nxt.active = 1'b0;
                end
            end
        end
    end

endmodule

/* hw/rtl/kmrd_state_mem.sv */
module kmrd_state_mem #(
    parameter int ROWS         = 8,
    parameter int KEYS_PER_ROW = 12,
    parameter int ROW_AW       = 3
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         rd_en,
    input  logic [ROW_AW-1:0]                            rd_addr,
    output kmrd_pkg::key_state_t [KEYS_PER_ROW-1:0]      rd_data,
    input  logic                                         wr_en,
    input  logic [ROW_AW-1:0]                            wr_addr,
    input  kmrd_pkg::key_state_t [KEYS_PER_ROW-1:0]      wr_data
);

    kmrd_pkg::key_state_t [KEYS_PER_ROW-1:0] mem [ROWS];
    kmrd_pkg::key_state_t [KEYS_PER_ROW-1:0] rd_data_reg;
    logic [ROWS-1:0]                         row_valid_reg;
    logic                                    rd_valid_reg;

    // Row valid bits: a row never written reads as all released.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    // Row storage with one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* tb/tb_key_matrix_release_debounce.sv */
`timescale 1ns / 1ps

module tb_key_matrix_release_debounce;

    localparam int N_ROWS = 8;
    localparam int N_KEYS = 12;
    localparam int N_PHASES = 8;
    localparam int PHASE_WORDS = 250;

    // Index with no register behind it; a write there must change nothing.
    localparam logic [kmrd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [kmrd_pkg::ROW_W-1:0] row;
        logic [kmrd_pkg::RAW_W-1:0] keys;
    } debounced_row_t;

    // Predicts the debounced row for every accepted sample word and checks
    // each result word against the oldest prediction.
    class debounce_scoreboard;
        bit                            pressed   [N_ROWS*N_KEYS];
        bit                            held_high [N_ROWS*N_KEYS];
        bit [kmrd_pkg::TIME_W-1:0]     low_since [N_ROWS*N_KEYS];
        bit [kmrd_pkg::DELAY_W-1:0]    delay_ms;
        bit [kmrd_pkg::KEYS_CFG_W-1:0] keys_cfg;
        debounced_row_t                expected_rows[$];
        int                            errors;
        int                            samples;
        int                            results;
        int                            releases;

        function new();
            delay_ms = kmrd_pkg::RELEASE_DELAY_RESET;
            keys_cfg = kmrd_pkg::KEYS_IN_USE_RESET;
            foreach (pressed[i])
            begin
                pressed[i]   = 1'b0;
                held_high[i] = 1'b0;
                low_since[i] = '0;
            end
        endfunction

        function void write_reg(bit [kmrd_pkg::CFG_IDX_W-1:0] idx,
                                bit [kmrd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                kmrd_pkg::REG_RELEASE_DELAY_MS: delay_ms = data[kmrd_pkg::DELAY_W-1:0];
                kmrd_pkg::REG_KEYS_IN_USE:      keys_cfg = data[kmrd_pkg::KEYS_CFG_W-1:0];
                default:                        ;
            endcase
        endfunction

        function void note_sample(bit [kmrd_pkg::ROW_W-1:0] row,
                                  bit [kmrd_pkg::RAW_W-1:0] raw,
                                  bit [kmrd_pkg::TIME_W-1:0] now);
            int                        used;
            int                        slot;
            bit                        level;
            bit [kmrd_pkg::TIME_W-1:0] elapsed;
            debounced_row_t            want;
            used = (keys_cfg > N_KEYS) ? N_KEYS : int'(keys_cfg);
            want.row  = row;
            want.keys = '0;
            samples++;
            if (row < N_ROWS)
            begin
                for (int j = 0; j < used; j++)
                begin
                    slot  = int'(row) * N_KEYS + j;
                    level = (j < kmrd_pkg::RAW_W) ? raw[j] : 1'b0;
                    // Press shows at once; the first low sample only starts the
                    // timer, and a later low sample releases once it has run out.
                    if (pressed[slot] != level)
                    begin
                        if (level)
                        begin
                            pressed[slot]   = 1'b1;
                            held_high[slot] = 1'b1;
                        end
                        else if (held_high[slot])
                        begin
                            held_high[slot] = 1'b0;
                            low_since[slot] = now;
                        end
                        else
                        begin
                            elapsed = now - low_since[slot];
                            if (elapsed >= {{(kmrd_pkg::TIME_W-kmrd_pkg::DELAY_W){1'b0}},
                                            delay_ms})
                            begin
                                pressed[slot] = 1'b0;
                                releases++;
                            end
                        end
                    end
                    if (pressed[slot] && j < kmrd_pkg::RAW_W)
                        want.keys[j] = 1'b1;
                end
            end
            expected_rows.push_back(want);
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_result(logic [kmrd_pkg::ROW_W-1:0] row, logic [kmrd_pkg::RAW_W-1:0] keys);
            debounced_row_t want;
            results++;
            if (expected_rows.size() == 0)
            begin
                report($sformatf("result row %0d keys %03h with none expected", row, keys));
                return;
            end
            want = expected_rows.pop_front();
            if (row !== want.row)
                report($sformatf("row_out %0d, expected %0d", row, want.row));
            if (keys !== want.keys)
                report($sformatf("debounced_keys %03h, expected %03h (row %0d)",
                                 keys, want.keys, want.row));
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   no_gaps;
    int   settings_used;

    debounce_scoreboard sb = new();

    kmrd_sample_if smp ();
    kmrd_result_if res ();
    kmrd_cfg_if    cfg_ch ();

    key_matrix_release_debounce u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfg_ch)
    );

    // Clock with a 10 ns period.
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Result side stalls at random except during the steady stretch.
    always @(negedge clk)
        res.ready = no_gaps || ($urandom_range(0, 99) >= 20);

    // Every accepted result word is checked at once.
    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
            sb.check_result(res.row_out, res.debounced_keys);
    end

    // Drives one sample word, with random idle cycles ahead of it outside the steady stretch.
    task automatic send_sample(logic [kmrd_pkg::ROW_W-1:0] row,
                               logic [kmrd_pkg::RAW_W-1:0] raw,
                               logic [kmrd_pkg::TIME_W-1:0] now);
        @(negedge clk);
        while (!no_gaps && $urandom_range(0, 99) < 20)
        begin
            smp.valid = 1'b0;
            @(negedge clk);
        end
        smp.valid     = 1'b1;
        smp.row_index = row;
        smp.raw_keys  = raw;
        smp.now_ms    = now;
        do
            @(posedge clk);
        while (!smp.ready);
        sb.note_sample(row, raw, now);
    endtask

    // Holds off the sample side until every predicted word has come back.
    task automatic wait_all_results();
        @(negedge clk);
        smp.valid = 1'b0;
        while (sb.expected_rows.size() != 0)
            @(posedge clk);
    endtask

    // Writes one configuration register; the block must be idle.
    task automatic write_reg(logic [kmrd_pkg::CFG_IDX_W-1:0] idx,
                             logic [kmrd_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_reg(idx, data);
        settings_used++;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Run limit, far above the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("Timeout: %0d results still outstanding", sb.expected_rows.size());
        $display("DONE: errors detected");
        $finish;
    end

    // Directed cases, then random phases over several register settings.
    initial
    begin
        logic [kmrd_pkg::RAW_W-1:0]      held_pattern [N_ROWS];
        logic [kmrd_pkg::DELAY_W-1:0]    phase_delay  [N_PHASES];
        logic [kmrd_pkg::CFG_DATA_W-1:0] phase_keys   [N_PHASES];
        logic [kmrd_pkg::TIME_W-1:0]     wall_ms;
        logic [kmrd_pkg::ROW_W-1:0]      row;
        logic [kmrd_pkg::RAW_W-1:0]      raw;

        rst_n        = 1'b0;
        no_gaps      = 1'b0;
        smp.valid    = 1'b0;
        smp.row_index = '0;
        smp.raw_keys = '0;
        smp.now_ms   = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = kmrd_pkg::REG_RELEASE_DELAY_MS;
        cfg_ch.data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: full press, timer start, early low, release on time.
        send_sample(3'd0, 12'hFFF, 32'd100);
        send_sample(3'd0, 12'h000, 32'd101);
        send_sample(3'd0, 12'h000, 32'd105);
        send_sample(3'd0, 12'h000, 32'd111);
        // Release timer running across the wrap of the timestamp.
        send_sample(3'd7, 12'hFFF, 32'hFFFF_FFFA);
        send_sample(3'd7, 12'h000, 32'hFFFF_FFFE);
        send_sample(3'd7, 12'h000, 32'd3);
        send_sample(3'd7, 12'h000, 32'd8);
        // Alternating keys, a bounce back high while the timer runs.
        send_sample(3'd3, 12'hAAA, 32'd50);
        send_sample(3'd3, 12'h555, 32'd51);
        send_sample(3'd3, 12'hFFF, 32'd52);
        send_sample(3'd3, 12'h000, 32'd70);

        // Zero delay still needs a second low sample.
        wait_all_results();
        write_reg(kmrd_pkg::REG_RELEASE_DELAY_MS, 8'd0);
        send_sample(3'd1, 12'hFFF, 32'd200);
        send_sample(3'd1, 12'h000, 32'd200);
        send_sample(3'd1, 12'h000, 32'd200);

        // No keys in use, then an oversized count, then a partial row.
        wait_all_results();
        write_reg(kmrd_pkg::REG_KEYS_IN_USE, 8'd0);
        send_sample(3'd2, 12'hFFF, 32'd300);
        wait_all_results();
        write_reg(kmrd_pkg::REG_KEYS_IN_USE, 8'hFF);
        send_sample(3'd2, 12'hFFF, 32'd301);
        wait_all_results();
        write_reg(kmrd_pkg::REG_KEYS_IN_USE, 8'd5);
        send_sample(3'd2, 12'h000, 32'd302);
        send_sample(3'd2, 12'h000, 32'd302);

        // Largest delay, one short of it and exactly on it.
        wait_all_results();
        write_reg(REG_SPARE, 8'h55);
        write_reg(kmrd_pkg::REG_RELEASE_DELAY_MS, 8'd255);
        write_reg(kmrd_pkg::REG_KEYS_IN_USE, 8'd12);
        send_sample(3'd4, 12'h001, 32'd0);
        send_sample(3'd4, 12'h000, 32'd1);
        send_sample(3'd4, 12'h000, 32'd255);
        send_sample(3'd4, 12'h000, 32'd256);

        phase_delay = '{8'd10, 8'd0, 8'd255, 8'd1, 8'd40, 8'd200, 8'd3, 8'd0};
        phase_keys  = '{8'd12, 8'd1, 8'd15, 8'd0, 8'd7, 8'd13, 8'd12, 8'd0};
        phase_delay[7] = 8'($urandom);
        phase_keys[7]  = 8'($urandom_range(1, 12));
        foreach (held_pattern[r])
            held_pattern[r] = 12'($urandom);
        wall_ms = $urandom;

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_all_results();
            write_reg(kmrd_pkg::REG_RELEASE_DELAY_MS, phase_delay[p]);
            write_reg(kmrd_pkg::REG_KEYS_IN_USE, phase_keys[p]);
            // One phase runs with no idling on either side, another crosses
            // the wrap of the millisecond counter.
            no_gaps = (p == 4);
            if (p == 5)
                wall_ms = 32'hFFFF_FF00;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (p == 2 && n == PHASE_WORDS / 2)
                    wait_all_results();
                row = 3'($urandom_range(0, N_ROWS - 1));
                // Keys mostly follow a held pattern per row, with contact
                // bounce on top and an occasional word of pure noise.
                if ($urandom_range(0, 9) == 0)
                    held_pattern[row] = 12'($urandom);
                raw = held_pattern[row];
                if ($urandom_range(0, 3) == 0)
                    raw = raw ^ 12'($urandom & $urandom & $urandom);
                if ($urandom_range(0, 19) == 0)
                    raw = 12'($urandom);
                wall_ms = wall_ms + $urandom_range(0, int'(phase_delay[p]) / 4 + 1);
                if ($urandom_range(0, 49) == 0)
                    wall_ms = $urandom;
                send_sample(row, raw, wall_ms);
            end
        end
        no_gaps = 1'b0;

        // Drain, then let the pipeline settle before the final check.
        wait_all_results();
        repeat (10) @(posedge clk);
        if (sb.expected_rows.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_rows.size()));

        $display("Summary: %0d sample words and %0d result words over %0d register writes.",
                 sb.samples, sb.results, settings_used);
        $display("Summary: %0d key releases predicted, delays 0 to 255, key counts 0 to 15.",
                 sb.releases);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/kmrd_pkg.sv
hw/rtl/kmrd_sample_if.sv
hw/rtl/kmrd_result_if.sv
hw/rtl/kmrd_cfg_if.sv
hw/rtl/kmrd_lane.sv
hw/rtl/kmrd_state_mem.sv
hw/rtl/key_matrix_release_debounce.sv
tb/tb_key_matrix_release_debounce.sv
